// File: sv/pairwise_gravity_potential_field_top_assert.svh
// Assertion macros for the pair kernel checker.
// Needs aclk and aresetn in the scope of each use.
`ifndef PAIRWISE_GRAVITY_POTENTIAL_FIELD_TOP_ASSERT_SVH
`define PAIRWISE_GRAVITY_POTENTIAL_FIELD_TOP_ASSERT_SVH

// same-cycle implication
`define PGPF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pgpf check failed");

// next-cycle implication
`define PGPF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pgpf check failed");

`endif

// File: sv/pgpf_pkg.sv
// Shared widths, types and the output clipping function of the pair kernel.
// No dependencies.
`default_nettype none
package pgpf_pkg;
    localparam int NAXIS    = 3;
    localparam int POS_W    = 32;
    localparam int MASS_W   = 32;
    localparam int MAG_W    = 32;
    localparam int SQ_W     = 2 * MAG_W + 2;
    localparam int ROOT_W   = MAG_W + 1;
    localparam int PROD_W   = MASS_W + MAG_W;
    localparam int CUBE_W   = 3 * ROOT_W;
    localparam int QUO_W    = 48;
    localparam int RES_W    = 48;
    localparam int POT_FRAC = 24;
    localparam int FLD_FRAC = 40;
    localparam int POT_HI_W = MASS_W + POT_FRAC - QUO_W;
    localparam int FLD_HI_W = PROD_W + FLD_FRAC - QUO_W;
    localparam int POT_PAD  = QUO_W - (MASS_W - POT_HI_W);
    localparam int FLD_PAD  = QUO_W - (PROD_W - FLD_HI_W);

    typedef struct packed {
        logic [NAXIS-1:0][MAG_W-1:0] mag;
        logic [NAXIS-1:0]            neg;
        logic [MASS_W-1:0]           m_first;
        logic [MASS_W-1:0]           m_second;
        logic                        zero;
    } sq_side_t;

    typedef struct packed {
        logic [NAXIS-1:0] neg;
        logic [NAXIS-1:0] nz;
    } sign_t;

    typedef struct packed {
        logic [1:0][RES_W-1:0]       pot;
        logic [NAXIS-1:0][RES_W-1:0] fld_first;
        logic [NAXIS-1:0][RES_W-1:0] fld_second;
        logic                        zero;
        logic                        sat;
    } result_t;

    typedef struct packed {
        logic [RES_W-1:0] value;
        logic             sat;
    } clip_t;

    // Clip a magnitude to the signed range, then apply the sign.
    function automatic clip_t clip_result(input logic [QUO_W-1:0] q, input logic ovf,
                                          input logic neg);
        logic [RES_W-1:0] lim;
        logic [RES_W-1:0] mag;
        clip_t            r;
        lim = neg ? (RES_W'(1) << (RES_W - 1)) : ((RES_W'(1) << (RES_W - 1)) - RES_W'(1));
        if (ovf || (RES_W'(q) > lim)) begin
            mag   = lim;
            r.sat = 1'b1;
        end else begin
            mag   = RES_W'(q);
            r.sat = 1'b0;
        end
        r.value = neg ? (~mag + RES_W'(1)) : mag;
        return r;
    endfunction
endpackage
`default_nettype wire

// File: sv/pgpf_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on pgpf_pkg.
`default_nettype none
module pgpf_sqrt_pipe import pgpf_pkg::*; #(
    parameter int IN_W   = SQ_W,
    parameter int OUT_W  = ROOT_W,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [OUT_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);
    logic [OUT_W:0]    valid_reg;
    logic [IN_W-1:0]   rem_reg  [0:OUT_W];
    logic [OUT_W-1:0]  root_reg [0:OUT_W];
    logic [SIDE_W-1:0] side_reg [0:OUT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[OUT_W-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= radicand;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 1; j <= OUT_W; j++) begin : g_step
        localparam int B = OUT_W - j;
        logic [IN_W-1:0] trial;
        logic            take;

        // (r + 2^b)^2 - r^2, with r holding only bits above b
        always_comb begin
            trial = (IN_W'(root_reg[j-1]) << (B + 1)) | (IN_W'(1) << (2 * B));
            take  = rem_reg[j-1] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
                root_reg[j] <= take ? (root_reg[j-1] | (OUT_W'(1) << B)) : root_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[OUT_W];
    assign root      = root_reg[OUT_W];
    assign side_out  = side_reg[OUT_W];
endmodule
`default_nettype wire

// File: sv/pgpf_div_pipe.sv
// Pipelined restoring divider, lanes sharing one divisor, one quotient bit per stage.
// Quotient is limited to QUO_W bits; larger quotients raise the lane's overflow flag.
// Depends on pgpf_pkg.
`default_nettype none
module pgpf_div_pipe import pgpf_pkg::*; #(
    parameter int NLANE  = 2,
    parameter int DIV_W  = ROOT_W,
    parameter int HI_W   = POT_HI_W,
    parameter int SIDE_W = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [DIV_W-1:0]             divisor,
    input  logic [NLANE-1:0][HI_W-1:0]   numer_hi,
    input  logic [NLANE-1:0][QUO_W-1:0]  numer_lo,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [NLANE-1:0][QUO_W-1:0]  quotient,
    output logic [NLANE-1:0]             ovf,
    output logic [SIDE_W-1:0]            side_out
);
    logic [QUO_W:0]                  valid_reg;
    logic [DIV_W-1:0]                dvs_reg  [0:QUO_W];
    logic [NLANE-1:0][DIV_W-1:0]     rem_reg  [0:QUO_W];
    logic [NLANE-1:0][QUO_W-1:0]     lo_reg   [0:QUO_W];
    logic [NLANE-1:0]                ovf_reg  [0:QUO_W];
    logic [SIDE_W-1:0]               side_reg [0:QUO_W];
    logic [NLANE-1:0]                ovf_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[QUO_W-1:0], in_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            ovf_c[l] = DIV_W'(numer_hi[l]) >= divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dvs_reg[0]  <= divisor;
            ovf_reg[0]  <= ovf_c;
            side_reg[0] <= side_in;
            for (int l = 0; l < NLANE; l++) begin
                rem_reg[0][l] <= DIV_W'(numer_hi[l]);
                lo_reg[0][l]  <= numer_lo[l];
            end
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        logic [NLANE-1:0][DIV_W-1:0] rem_next;
        logic [NLANE-1:0][QUO_W-1:0] lo_next;

        // shift the next dividend bit in from the top, quotient bit out at the bottom
        always_comb begin
            logic [DIV_W:0] trial;
            logic           ge;
            for (int l = 0; l < NLANE; l++) begin
                trial       = {rem_reg[j-1][l], lo_reg[j-1][l][QUO_W-1]};
                ge          = trial >= {1'b0, dvs_reg[j-1]};
                rem_next[l] = ge ? DIV_W'(trial - {1'b0, dvs_reg[j-1]}) : DIV_W'(trial);
                lo_next[l]  = {lo_reg[j-1][l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dvs_reg[j]  <= dvs_reg[j-1];
                rem_reg[j]  <= rem_next;
                lo_reg[j]   <= lo_next;
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quotient  = lo_reg[QUO_W];
    assign ovf       = ovf_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];
endmodule
`default_nettype wire

// File: sv/pairwise_gravity_potential_field_top.sv
// Top level of the direct gravity pair kernel: difference, square root, cube and divide pipes.
// Depends on pgpf_pkg, pgpf_sqrt_pipe and pgpf_div_pipe.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    two centres (Q16.16), two masses (Q16.16)
//  m_        out        m_valid/m_ready    two potentials, six field terms (Q24.24), flags
//  cfg_      in         cfg_we             field_mode
//
// One item per cycle while the skid register is empty, through 91 register stages. The
// square root takes 34 of those stages and each quotient pipe 49. All stages but the
// output register advance on one enable, held only while the skid register is full,
// so a stall freezes the pipe without loss. Synchronous active-low reset clears the
// valid bits and sets field_mode to 1.
`default_nettype none
module pairwise_gravity_potential_field_top import pgpf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_first_x,
    input  logic signed [POS_W-1:0] s_first_y,
    input  logic signed [POS_W-1:0] s_first_z,
    input  logic signed [POS_W-1:0] s_second_x,
    input  logic signed [POS_W-1:0] s_second_y,
    input  logic signed [POS_W-1:0] s_second_z,
    input  logic [MASS_W-1:0]       s_first_mass,
    input  logic [MASS_W-1:0]       s_second_mass,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RES_W-1:0] m_potential_first,
    output logic signed [RES_W-1:0] m_potential_second,
    output logic signed [RES_W-1:0] m_field_first_x,
    output logic signed [RES_W-1:0] m_field_first_y,
    output logic signed [RES_W-1:0] m_field_first_z,
    output logic signed [RES_W-1:0] m_field_second_x,
    output logic signed [RES_W-1:0] m_field_second_y,
    output logic signed [RES_W-1:0] m_field_second_z,
    output logic                    m_zero_distance,
    output logic                    m_saturated
);
    logic field_mode_reg;
    logic en;
    logic push;

    logic valid_a_reg, valid_b_reg, valid_c_reg, valid_d_reg, valid_e_reg, valid_f_reg;
    logic valid_g_reg;

    logic [POS_W-1:0] pos_a [NAXIS];
    logic [POS_W-1:0] pos_b [NAXIS];
    logic [POS_W:0]   diff_c [NAXIS];
    logic [POS_W:0]   abs_c [NAXIS];
    sq_side_t         side_a_next;

    sq_side_t                     side_a_reg, side_b_reg, side_c_reg;
    logic [NAXIS-1:0][2*MAG_W-1:0] sq_b_reg;
    logic [SQ_W-1:0]              sum_c_reg;

    logic              sqrt_valid;
    logic [ROOT_W-1:0] sqrt_root;
    sq_side_t          sqrt_side;

    logic [2*ROOT_W-1:0]               r2_d_reg;
    logic [2*ROOT_W-1:0]               r3lo_e_reg, r3hi_e_reg;
    logic [CUBE_W-1:0]                 cube_f_reg;
    logic [ROOT_W-1:0]                 root_d_reg, root_e_reg, root_f_reg;
    logic [2*NAXIS-1:0][PROD_W-1:0]    prod_d_reg, prod_e_reg, prod_f_reg;
    sign_t                             sign_d_reg, sign_e_reg, sign_f_reg;
    logic [MASS_W-1:0]                 mf_d_reg, mf_e_reg, mf_f_reg;
    logic [MASS_W-1:0]                 ms_d_reg, ms_e_reg, ms_f_reg;
    logic                              zero_d_reg, zero_e_reg, zero_f_reg;

    logic [1:0][POT_HI_W-1:0]        pot_hi;
    logic [1:0][QUO_W-1:0]           pot_lo;
    logic [2*NAXIS-1:0][FLD_HI_W-1:0] fld_hi;
    logic [2*NAXIS-1:0][QUO_W-1:0]   fld_lo;

    logic                          pot_valid, fld_valid;
    logic [1:0][QUO_W-1:0]         pot_q;
    logic [1:0]                    pot_ovf;
    logic                          pot_zero;
    logic [2*NAXIS-1:0][QUO_W-1:0] fld_q;
    logic [2*NAXIS-1:0]            fld_ovf;
    sign_t                         fld_sign;

    result_t res_g_next, res_g_reg;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            field_mode_reg <= cfg_wdata;
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign push    = en && valid_g_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= s_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= sqrt_valid;
            valid_e_reg <= valid_d_reg;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= pot_valid && fld_valid;
        end
    end

    // stage A: component differences and their magnitudes
    assign pos_a[0] = s_first_x;
    assign pos_a[1] = s_first_y;
    assign pos_a[2] = s_first_z;
    assign pos_b[0] = s_second_x;
    assign pos_b[1] = s_second_y;
    assign pos_b[2] = s_second_z;

    always_comb begin
        for (int k = 0; k < NAXIS; k++) begin
            diff_c[k] = {pos_a[k][POS_W-1], pos_a[k]} - {pos_b[k][POS_W-1], pos_b[k]};
            abs_c[k]  = diff_c[k][POS_W] ? (~diff_c[k] + (POS_W+1)'(1)) : diff_c[k];
            side_a_next.mag[k] = abs_c[k][MAG_W-1:0];
            side_a_next.neg[k] = diff_c[k][POS_W];
        end
        side_a_next.m_first  = s_first_mass;
        side_a_next.m_second = s_second_mass;
        side_a_next.zero     = (diff_c[0] == '0) && (diff_c[1] == '0) && (diff_c[2] == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_a_reg <= side_a_next;
            side_b_reg <= side_a_reg;
            side_c_reg <= side_b_reg;
            for (int k = 0; k < NAXIS; k++) begin
                sq_b_reg[k] <= side_a_reg.mag[k] * side_a_reg.mag[k];
            end
            sum_c_reg <= SQ_W'(sq_b_reg[0]) + SQ_W'(sq_b_reg[1]) + SQ_W'(sq_b_reg[2]);
        end
    end

    pgpf_sqrt_pipe #(
        .IN_W   (SQ_W),
        .OUT_W  (ROOT_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_c_reg),
        .radicand  (sum_c_reg),
        .side_in   (side_c_reg),
        .out_valid (sqrt_valid),
        .root      (sqrt_root),
        .side_out  (sqrt_side)
    );

    // stages D to F: R^2 and mass products, partial products of R^3, then R^3
    always_ff @(posedge aclk) begin
        if (en) begin
            r2_d_reg   <= sqrt_root * sqrt_root;
            root_d_reg <= sqrt_root;
            for (int k = 0; k < NAXIS; k++) begin
                prod_d_reg[k]         <= sqrt_side.m_second * sqrt_side.mag[k];
                prod_d_reg[NAXIS + k] <= sqrt_side.m_first * sqrt_side.mag[k];
                sign_d_reg.neg[k]     <= sqrt_side.neg[k];
                sign_d_reg.nz[k]      <= |sqrt_side.mag[k];
            end
            mf_d_reg   <= sqrt_side.m_first;
            ms_d_reg   <= sqrt_side.m_second;
            zero_d_reg <= sqrt_side.zero;

            r3lo_e_reg <= r2_d_reg[ROOT_W-1:0] * root_d_reg;
            r3hi_e_reg <= r2_d_reg[2*ROOT_W-1:ROOT_W] * root_d_reg;
            root_e_reg <= root_d_reg;
            prod_e_reg <= prod_d_reg;
            sign_e_reg <= sign_d_reg;
            mf_e_reg   <= mf_d_reg;
            ms_e_reg   <= ms_d_reg;
            zero_e_reg <= zero_d_reg;

            cube_f_reg <= CUBE_W'(r3lo_e_reg) + (CUBE_W'(r3hi_e_reg) << ROOT_W);
            root_f_reg <= root_e_reg;
            prod_f_reg <= prod_e_reg;
            sign_f_reg <= sign_e_reg;
            mf_f_reg   <= mf_e_reg;
            ms_f_reg   <= ms_e_reg;
            zero_f_reg <= zero_e_reg;
        end
    end

    // split each dividend at the quotient width: the top part seeds the remainder
    always_comb begin
        pot_hi[0] = ms_f_reg[MASS_W-1 -: POT_HI_W];
        pot_hi[1] = mf_f_reg[MASS_W-1 -: POT_HI_W];
        pot_lo[0] = {ms_f_reg[MASS_W-POT_HI_W-1:0], POT_PAD'(0)};
        pot_lo[1] = {mf_f_reg[MASS_W-POT_HI_W-1:0], POT_PAD'(0)};
        for (int l = 0; l < 2 * NAXIS; l++) begin
            fld_hi[l] = prod_f_reg[l][PROD_W-1 -: FLD_HI_W];
            fld_lo[l] = {prod_f_reg[l][PROD_W-FLD_HI_W-1:0], FLD_PAD'(0)};
        end
    end

    pgpf_div_pipe #(
        .NLANE  (2),
        .DIV_W  (ROOT_W),
        .HI_W   (POT_HI_W),
        .SIDE_W (1)
    ) u_div_pot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_f_reg),
        .divisor   (root_f_reg),
        .numer_hi  (pot_hi),
        .numer_lo  (pot_lo),
        .side_in   (zero_f_reg),
        .out_valid (pot_valid),
        .quotient  (pot_q),
        .ovf       (pot_ovf),
        .side_out  (pot_zero)
    );

    pgpf_div_pipe #(
        .NLANE  (2 * NAXIS),
        .DIV_W  (CUBE_W),
        .HI_W   (FLD_HI_W),
        .SIDE_W ($bits(sign_t))
    ) u_div_fld (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_f_reg),
        .divisor   (cube_f_reg),
        .numer_hi  (fld_hi),
        .numer_lo  (fld_lo),
        .side_in   (sign_f_reg),
        .out_valid (fld_valid),
        .quotient  (fld_q),
        .ovf       (fld_ovf),
        .side_out  (fld_sign)
    );

    // stage G: clip, sign, mode and coincident-centre override
    always_comb begin
        clip_t c0, c1, cf, cs;
        logic  sat_any;
        res_g_next = '0;
        c0 = clip_result(pot_q[0], pot_ovf[0], 1'b1);
        c1 = clip_result(pot_q[1], pot_ovf[1], 1'b1);
        res_g_next.pot[0] = c0.value;
        res_g_next.pot[1] = c1.value;
        sat_any = c0.sat || c1.sat;
        for (int k = 0; k < NAXIS; k++) begin
            cf = clip_result(fld_q[k], fld_ovf[k], fld_sign.neg[k]);
            cs = clip_result(fld_q[NAXIS + k], fld_ovf[NAXIS + k],
                             !fld_sign.neg[k] && fld_sign.nz[k]);
            if (field_mode_reg) begin
                res_g_next.fld_first[k]  = cf.value;
                res_g_next.fld_second[k] = cs.value;
                sat_any = sat_any || cf.sat || cs.sat;
            end
        end
        res_g_next.sat = sat_any;
        if (pot_zero) begin
            res_g_next      = '0;
            res_g_next.zero = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_g_reg <= res_g_next;
        end
    end

    // output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_g_reg;
        end else if (push) begin
            skid_reg <= res_g_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_potential_first  = out_reg.pot[0];
    assign m_potential_second = out_reg.pot[1];
    assign m_field_first_x    = out_reg.fld_first[0];
    assign m_field_first_y    = out_reg.fld_first[1];
    assign m_field_first_z    = out_reg.fld_first[2];
    assign m_field_second_x   = out_reg.fld_second[0];
    assign m_field_second_y   = out_reg.fld_second[1];
    assign m_field_second_z   = out_reg.fld_second[2];
    assign m_zero_distance    = out_reg.zero;
    assign m_saturated        = out_reg.sat;
endmodule
`default_nettype wire

// File: sv/pgpf_checker.sv
// Port-level checker for the pair kernel, bound to the top level.
// Depends on pgpf_pkg and the assertion macro header.
`default_nettype none
`include "pairwise_gravity_potential_field_top_assert.svh"
module pgpf_checker import pgpf_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [RES_W-1:0] m_potential_first,
    input logic signed [RES_W-1:0] m_potential_second,
    input logic signed [RES_W-1:0] m_field_first_x,
    input logic signed [RES_W-1:0] m_field_first_y,
    input logic signed [RES_W-1:0] m_field_first_z,
    input logic signed [RES_W-1:0] m_field_second_x,
    input logic signed [RES_W-1:0] m_field_second_y,
    input logic signed [RES_W-1:0] m_field_second_z,
    input logic                    m_zero_distance,
    input logic                    m_saturated
);
    logic [8*RES_W+1:0] out_bus;
    logic               all_zero;
    logic               pots_nonpos;
    logic               first_x_pos;
    logic               second_x_nonpos;

    assign out_bus = {m_potential_first, m_potential_second, m_field_first_x, m_field_first_y,
                      m_field_first_z, m_field_second_x, m_field_second_y, m_field_second_z,
                      m_zero_distance, m_saturated};
    assign all_zero = m_potential_first == '0 && m_potential_second == '0
                      && m_field_first_x == '0 && m_field_first_y == '0
                      && m_field_first_z == '0 && m_field_second_x == '0
                      && m_field_second_y == '0 && m_field_second_z == '0;
    assign pots_nonpos = (m_potential_first[RES_W-1] || m_potential_first == '0)
                         && (m_potential_second[RES_W-1] || m_potential_second == '0);
    assign first_x_pos     = !m_field_first_x[RES_W-1] && m_field_first_x != '0;
    assign second_x_nonpos = m_field_second_x[RES_W-1] || m_field_second_x == '0;

    // hold a stalled result
    `PGPF_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(out_bus))

    // coincident centres give all-zero results without saturation
    `PGPF_ASSERT_IMP(a_zero_dist, m_valid && m_zero_distance, all_zero && !m_saturated)

    // potentials are never positive
    `PGPF_ASSERT_IMP(a_pot_sign, m_valid, pots_nonpos)

    // where the first x field term is positive, the second x field term is not
    `PGPF_ASSERT_IMP(a_fld_oppose, m_valid && first_x_pos, second_x_nonpos)
endmodule

bind pairwise_gravity_potential_field_top pgpf_checker u_pgpf_checker (.*);
`default_nettype wire

// File: tb/sv/tb_pairwise_gravity_potential_field_top.sv
// Self-checking testbench for the direct gravity pair kernel: directed table, then random pairs.
// Depends on pgpf_pkg and pairwise_gravity_potential_field_top.
`timescale 1ns / 100ps
`default_nettype none
module tb_pairwise_gravity_potential_field_top;
    import pgpf_pkg::*;

    localparam int LATENCY   = 91;
    localparam int STALL_MAX = 2000;
    localparam int N_RANDOM  = 1750;

    typedef struct {
        logic signed [POS_W-1:0] p0 [3];
        logic signed [POS_W-1:0] p1 [3];
        logic [MASS_W-1:0]       m0;
        logic [MASS_W-1:0]       m1;
    } pair_in_t;

    typedef struct {
        logic [RES_W-1:0] pot0;
        logic [RES_W-1:0] pot1;
        logic [RES_W-1:0] fld0 [3];
        logic [RES_W-1:0] fld1 [3];
        logic             zero;
        logic             sat;
    } pair_out_t;

    typedef struct {
        pair_in_t  stim;
        bit        typed;
        pair_out_t want;
    } table_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [POS_W-1:0] s_first_x = '0, s_first_y = '0, s_first_z = '0;
    logic signed [POS_W-1:0] s_second_x = '0, s_second_y = '0, s_second_z = '0;
    logic [MASS_W-1:0] s_first_mass = '0, s_second_mass = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [RES_W-1:0] m_potential_first, m_potential_second;
    logic signed [RES_W-1:0] m_field_first_x, m_field_first_y, m_field_first_z;
    logic signed [RES_W-1:0] m_field_second_x, m_field_second_y, m_field_second_z;
    logic m_zero_distance, m_saturated;

    bit        field_on = 1'b1;
    bit        calm = 1'b0;
    bit        failed = 1'b0;
    int        idle_cycles = 0;
    pair_out_t pending_results [$];

    always #5 aclk = ~aclk;

    pairwise_gravity_potential_field_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_first_x(s_first_x), .s_first_y(s_first_y), .s_first_z(s_first_z),
        .s_second_x(s_second_x), .s_second_y(s_second_y), .s_second_z(s_second_z),
        .s_first_mass(s_first_mass), .s_second_mass(s_second_mass),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_potential_first(m_potential_first), .m_potential_second(m_potential_second),
        .m_field_first_x(m_field_first_x), .m_field_first_y(m_field_first_y),
        .m_field_first_z(m_field_first_z), .m_field_second_x(m_field_second_x),
        .m_field_second_y(m_field_second_y), .m_field_second_z(m_field_second_z),
        .m_zero_distance(m_zero_distance), .m_saturated(m_saturated)
    );

    function automatic logic [RES_W-1:0] clip_signed(input logic [127:0] mag, input bit neg,
                                                     inout bit sat);
        logic [127:0] lim;
        logic [RES_W-1:0] v;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
        end
        v = mag[RES_W-1:0];
        return neg ? (~v + 1'b1) : v;
    endfunction

    function automatic pair_out_t gravity_pair(input pair_in_t p, input bit with_field);
        pair_out_t    o;
        logic [127:0] mag [3];
        bit           neg [3];
        logic [127:0] sq, root, cand, cube;
        logic signed [POS_W:0] d;
        bit           sat;
        sq = '0;
        sat = 1'b0;
        o.pot0 = '0;
        o.pot1 = '0;
        o.zero = 1'b0;
        for (int k = 0; k < 3; k++) begin
            o.fld0[k] = '0;
            o.fld1[k] = '0;
            d = {p.p0[k][POS_W-1], p.p0[k]} - {p.p1[k][POS_W-1], p.p1[k]};
            neg[k] = d[POS_W];
            mag[k] = neg[k] ? 128'(-d) : 128'(d);
            sq += mag[k] * mag[k];
        end
        if (sq == 0) begin
            o.zero = 1'b1;
            o.sat = 1'b0;
            return o;
        end
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq) root = cand;
        end
        o.pot0 = clip_signed((128'(p.m1) << 24) / root, 1'b1, sat);
        o.pot1 = clip_signed((128'(p.m0) << 24) / root, 1'b1, sat);
        if (with_field) begin
            cube = root * root * root;
            for (int k = 0; k < 3; k++) begin
                o.fld0[k] = clip_signed(((128'(p.m1) * mag[k]) << 40) / cube, neg[k], sat);
                o.fld1[k] = clip_signed(((128'(p.m0) * mag[k]) << 40) / cube,
                                        !neg[k] && mag[k] != 0, sat);
            end
        end
        o.sat = sat;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [RES_W-1:0] want,
                                        input logic [RES_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Scoreboard: compare each result with the oldest pending one.
    always @(posedge aclk) begin
        pair_out_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item");
                failed = 1'b1;
            end else begin
                w = pending_results.pop_front();
                check_field("potential_first", w.pot0, m_potential_first);
                check_field("potential_second", w.pot1, m_potential_second);
                check_field("field_first_x", w.fld0[0], m_field_first_x);
                check_field("field_first_y", w.fld0[1], m_field_first_y);
                check_field("field_first_z", w.fld0[2], m_field_first_z);
                check_field("field_second_x", w.fld1[0], m_field_second_x);
                check_field("field_second_y", w.fld1[1], m_field_second_y);
                check_field("field_second_z", w.fld1[2], m_field_second_z);
                check_field("zero_distance", RES_W'(w.zero), RES_W'(m_zero_distance));
                check_field("saturated", RES_W'(w.sat), RES_W'(m_saturated));
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall in bursts, none in the last part.
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
    end

    task automatic send_pair(input pair_in_t p, input bit typed, input pair_out_t want);
        pair_out_t model;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        model = gravity_pair(p, field_on);
        if (typed) begin
            // potential-only mode zeroes the field terms
            if (!field_on) begin
                for (int k = 0; k < 3; k++) begin
                    want.fld0[k] = '0;
                    want.fld1[k] = '0;
                end
                want.sat = model.sat;
            end
            model = want;
        end
        {s_first_x, s_first_y, s_first_z} = {p.p0[0], p.p0[1], p.p0[2]};
        {s_second_x, s_second_y, s_second_z} = {p.p1[0], p.p1[1], p.p1[2]};
        s_first_mass = p.m0;
        s_second_mass = p.m1;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.insert(pending_results.size(), model);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    task automatic set_field_mode(input bit on);
        s_valid = 1'b0;
        drain_results();
        cfg_wdata = on;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        field_on = on;
    endtask

    function automatic pair_in_t make_pair(input logic [31:0] ax, ay, az, bx, by, bz, ma, mb);
        pair_in_t p;
        p.p0[0] = ax; p.p0[1] = ay; p.p0[2] = az;
        p.p1[0] = bx; p.p1[1] = by; p.p1[2] = bz;
        p.m0 = ma;
        p.m1 = mb;
        return p;
    endfunction

    function automatic pair_in_t random_pair();
        pair_in_t p;
        int kind;
        kind = $urandom_range(0, 11);
        for (int k = 0; k < 3; k++) begin
            p.p0[k] = $urandom;
            case (kind)
                0: p.p1[k] = p.p0[k];
                1: p.p1[k] = $urandom;
                default: p.p1[k] = p.p0[k] - ($signed($urandom) >>> $urandom_range(4, 31));
            endcase
        end
        p.m0 = $urandom >> $urandom_range(0, 31);
        p.m1 = $urandom >> $urandom_range(0, 31);
        return p;
    endfunction

    table_row_t directed [$];

    function automatic void add_row(input pair_in_t p, input bit typed, input pair_out_t want);
        table_row_t r;
        r.stim  = p;
        r.typed = typed;
        r.want  = want;
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        pair_out_t none, z, sat_row;
        none = '{default: '0, fld0: '{default: '0}, fld1: '{default: '0}};
        z = none;
        z.zero = 1'b1;
        sat_row = none;
        sat_row.pot0 = 48'h8000_0000_0000;
        sat_row.pot1 = 48'h8000_0000_0000;
        sat_row.fld0[0] = 48'h7fff_ffff_ffff;
        sat_row.fld1[0] = 48'h8000_0000_0000;
        sat_row.sat = 1'b1;

        // coincident centres, including the extremes
        add_row(make_pair(0, 0, 0, 0, 0, 0, 32'hffffffff, 32'hffffffff), 1, z);
        add_row(make_pair(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 32'h12345678, 0), 1, z);
        // one unit apart, full masses: the potentials and the x field terms clip
        add_row(make_pair(1, 0, 0, 0, 0, 0, 32'hffffffff, 32'hffffffff), 1, sat_row);
        // zero masses give zero results, no flags
        add_row(make_pair(32'h10000, 0, 0, 0, 0, 0, 0, 0), 1, none);
        // widest separations on each axis and on all three
        add_row(make_pair(32'h7fffffff, 0, 0, 32'h80000000, 0, 0,
                          32'hffffffff, 32'hffffffff), 0, none);
        add_row(make_pair(0, 32'h80000000, 0, 0, 32'h7fffffff, 0,
                          32'hffffffff, 1), 0, none);
        add_row(make_pair(0, 0, 32'h7fffffff, 0, 0, 32'h80000000,
                          1, 32'hffffffff), 0, none);
        add_row(make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                          32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff), 0, none);
        // unit-scale masses one apart on each sign, a diagonal, and one-LSB offsets
        add_row(make_pair(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 32'h10000), 0, none);
        add_row(make_pair(0, 32'hffff0000, 0, 0, 0, 0, 32'h10000, 32'h20000), 0, none);
        add_row(make_pair(32'h30000, 32'h40000, 32'hfffb0000, 0, 0, 0,
                          32'h50000, 32'h8000), 0, none);
        add_row(make_pair(1, 1, 1, 0, 0, 0, 1, 1), 0, none);
        add_row(make_pair(32'hffffffff, 0, 0, 0, 0, 0, 32'h7fffffff, 1), 0, none);

        @(negedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset leaves field mode on; repeat the table in potential-only mode
        foreach (directed[i]) send_pair(directed[i].stim, directed[i].typed, directed[i].want);
        set_field_mode(1'b0);
        foreach (directed[i]) send_pair(directed[i].stim, directed[i].typed, directed[i].want);
        repeat (N_RANDOM / 4) send_pair(random_pair(), 1'b0, none);
        set_field_mode(1'b1);
        repeat (N_RANDOM / 2) send_pair(random_pair(), 1'b0, none);
        set_field_mode(1'b0);
        repeat (N_RANDOM / 8) send_pair(random_pair(), 1'b0, none);
        set_field_mode(1'b1);
        calm = 1'b1;
        repeat (N_RANDOM / 8) send_pair(random_pair(), 1'b0, none);
        s_valid = 1'b0;
        drain_results();

        if (!failed) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: pairwise_gravity_potential_field_top.f
+incdir+sv
sv/pgpf_pkg.sv
sv/pgpf_sqrt_pipe.sv
sv/pgpf_div_pipe.sv
sv/pairwise_gravity_potential_field_top.sv
sv/pgpf_checker.sv
tb/sv/tb_pairwise_gravity_potential_field_top.sv
